@@ src/servo_mixer_with_rate_damping_defines.svh @@
`ifndef SERVO_MIXER_WITH_RATE_DAMPING_DEFINES_SVH
`define SERVO_MIXER_WITH_RATE_DAMPING_DEFINES_SVH

// Concurrent checks clocked on clk and held off during rst.
`define SMX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define SMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/smx_pkg.sv @@
package smx_pkg;

  localparam int STAGES  = 9;
  localparam int CMD_W   = 16;
  localparam int WIDE_W  = 27;  // damped and trimmed commands
  localparam int RUD_W   = 33;  // rudder after autocoordination
  localparam int MIX_W   = 51;  // surface mix products and sums

  // mode_flags bit positions
  localparam int FLAG_ROLL_DAMP  = 0;
  localparam int FLAG_PITCH_DAMP = 1;
  localparam int FLAG_YAW_DAMP   = 2;
  localparam int FLAG_TUNE       = 3;
  localparam int FLAG_AUTOCOORD  = 4;
  localparam int FLAG_THR_TRIM   = 5;
  localparam int FLAG_FLAP_TRIM  = 6;
  localparam int FLAG_ELEVON     = 7;
  localparam int FLAG_FLAPERON   = 8;
  localparam int FLAG_VTAIL      = 9;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_DAMP     = 3'd1;
  localparam logic [2:0] REG_CMD_MIX  = 3'd2;
  localparam logic [2:0] REG_WING_MIX = 3'd3;
  localparam logic [2:0] REG_TAIL_MIX = 3'd4;

  localparam logic [9:0]  MODE_RST     = 10'd0;
  localparam logic [63:0] DAMP_RST     = 64'h2000_0000_0000_0000;
  localparam logic [47:0] CMD_MIX_RST  = 48'h019A_FE66_0800;
  localparam logic [63:0] WING_MIX_RST = 64'h1000_1000_1000_1000;
  localparam logic [31:0] TAIL_MIX_RST = 32'h1000_1000;

  localparam logic [13:0] TUNE_ONE = 14'd4096;
  localparam logic [13:0] TUNE_MAX = 14'd8192;

  typedef struct packed {
    logic signed [15:0] throttle_arm;
    logic signed [15:0] throttle_command;
    logic signed [15:0] aileron_command;
    logic signed [15:0] elevator_command;
    logic signed [15:0] rudder_command;
    logic signed [15:0] flap_command;
    logic signed [15:0] gear_command;
    logic signed [15:0] roll_rate;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] tune_knob;
  } in_t;

  typedef struct packed {
    logic signed [15:0] throttle_out;
    logic signed [15:0] left_surface_out;
    logic signed [15:0] pitch_surface_out;
    logic signed [15:0] yaw_surface_out;
    logic signed [15:0] flap_out;
    logic signed [15:0] gear_out;
  } out_t;

  typedef struct packed {
    logic [9:0]  mode;
    logic [63:0] damp;
    logic [47:0] cmd_mix;
    logic [63:0] wing_mix;
    logic [31:0] tail_mix;
  } cfg_t;

  typedef struct packed {
    logic [STAGES-1:0] load;
    logic [STAGES-1:0] valid;
  } pipe_ctl_t;

  // commands after damping and trim
  typedef struct packed {
    logic                      arm_pos;
    logic signed [CMD_W-1:0]   thr;
    logic signed [WIDE_W-1:0]  ail;
    logic signed [WIDE_W-1:0]  ele;
    logic signed [WIDE_W-1:0]  rud;
    logic signed [CMD_W-1:0]   flp;
    logic signed [CMD_W-1:0]   gear;
  } damp_t;

endpackage

@@ src/servo_mixer_with_rate_damping.sv @@
// Servo mixer with rate damping: each transfer on in_data (commands Q1.14,
// body rates Q3.12, tune knob) yields one transfer on out_data with six
// Q1.14 actuator values (surface outputs saturated). The datapath is a
// nine-stage pipeline (input products, tune, tune*gain, *rate, damping
// sums, autocoordination product, rudder sum, surface mix products,
// round/saturate/select), and one item is taken every cycle while the
// output is not stalled. Each stage holds when its successor is full and
// stalled, so bubbles close up under output back-pressure. Configuration
// writes take effect at once and must only be issued while the pipeline is empty.
module servo_mixer_with_rate_damping (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  smx_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output smx_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data
);
  import smx_pkg::*;

  cfg_t      cfg;
  pipe_ctl_t ctl;
  damp_t     mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_RST;
      cfg.damp     <= DAMP_RST;
      cfg.cmd_mix  <= CMD_MIX_RST;
      cfg.wing_mix <= WING_MIX_RST;
      cfg.tail_mix <= TAIL_MIX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:     cfg.mode     <= cfg_data[9:0];
        REG_DAMP:     cfg.damp     <= cfg_data;
        REG_CMD_MIX:  cfg.cmd_mix  <= cfg_data[47:0];
        REG_WING_MIX: cfg.wing_mix <= cfg_data;
        REG_TAIL_MIX: cfg.tail_mix <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  smx_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  smx_damp u_damp (
    .clk     (clk),
    .ctl     (ctl),
    .cfg     (cfg),
    .in_data (in_data),
    .mid     (mid)
  );

  smx_mix u_mix (
    .clk      (clk),
    .ctl      (ctl),
    .cfg      (cfg),
    .mid      (mid),
    .out_data (out_data)
  );

endmodule

@@ src/smx_pipe_ctrl.sv @@
`include "servo_mixer_with_rate_damping_defines.svh"

module smx_pipe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output smx_pkg::pipe_ctl_t ctl
);
  import smx_pkg::*;

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] load;

  // a stage loads when it is empty or its successor moves on
  always_comb begin
    load[STAGES-1] = !valid[STAGES-1] || out_ready;
    for (int k = STAGES-2; k >= 0; k--) begin
      load[k] = !valid[k] || load[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (load[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign in_ready  = load[0];
  assign out_valid = valid[STAGES-1];
  assign ctl.load  = load;
  assign ctl.valid = valid;

  `SMX_ASSERT_IMP(a_load_chain, 1'b1, ((load >> 1) & ~load) == '0, "stage moved into a held stage")
  `SMX_ASSERT_IMP(a_hold, !$past(rst), ($past(valid & ~load) & ~valid) == '0, "stalled item dropped")
  `SMX_ASSERT_IMP(a_count, !$past(rst), $countones(valid) == $past($countones(valid)) + $past(in_valid && in_ready) - $past(out_valid && out_ready), "item count mismatch")
  `SMX_ASSERT_NEXT(a_drain, out_valid && out_ready && !valid[STAGES-2], !out_valid, "result repeated")

endmodule

@@ src/smx_damp.sv @@
module smx_damp (
  input  logic               clk,
  input  smx_pkg::pipe_ctl_t ctl,
  input  smx_pkg::cfg_t      cfg,
  input  smx_pkg::in_t       in_data,
  output smx_pkg::damp_t     mid
);
  import smx_pkg::*;

  // stage 0: input capture, tune and trim products
  in_t                s0_item;
  logic signed [31:0] s0_tune_prod;
  logic signed [31:0] s0_trim_thr;
  logic signed [31:0] s0_trim_flp;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s0_item      <= in_data;
      s0_tune_prod <= $signed(cfg.damp[63:48]) * in_data.tune_knob;
      s0_trim_thr  <= $signed(cfg.cmd_mix[31:16]) * in_data.throttle_command;
      s0_trim_flp  <= $signed(cfg.cmd_mix[47:32]) * in_data.flap_command;
    end
  end

  // stage 1: tune round and clamp, trim round
  logic [32:0]        tune_sum;
  logic [18:0]        tune_q;
  logic [13:0]        tune_next;
  logic signed [32:0] thr_r;
  logic signed [32:0] flp_r;
  logic signed [20:0] thr_g;
  logic signed [20:0] flp_g;
  logic signed [21:0] trim_next;

  always_comb begin
    tune_sum = {1'b0, s0_tune_prod} + 33'd8192;
    tune_q   = tune_sum[32:14];
    if (!cfg.mode[FLAG_TUNE]) begin
      tune_next = TUNE_ONE;
    end else if (s0_tune_prod[31]) begin
      tune_next = '0;
    end else if (tune_q > 19'(TUNE_MAX)) begin
      tune_next = TUNE_MAX;
    end else begin
      tune_next = tune_q[13:0];
    end
    thr_r = {s0_trim_thr[31], s0_trim_thr} + 33'sd2048;
    flp_r = {s0_trim_flp[31], s0_trim_flp} + 33'sd2048;
    thr_g = cfg.mode[FLAG_THR_TRIM]  ? $signed(thr_r[32:12]) : '0;
    flp_g = cfg.mode[FLAG_FLAP_TRIM] ? $signed(flp_r[32:12]) : '0;
    trim_next = 22'(thr_g) + 22'(flp_g);
  end

  in_t                s1_item;
  logic [13:0]        s1_tune;
  logic signed [21:0] s1_trim;

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s1_item <= s0_item;
      s1_tune <= tune_next;
      s1_trim <= trim_next;
    end
  end

  // stage 2: tune * gain
  in_t                s2_item;
  logic signed [21:0] s2_trim;
  logic signed [30:0] s2_tg_roll;
  logic signed [30:0] s2_tg_pitch;
  logic signed [30:0] s2_tg_yaw;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s2_item     <= s1_item;
      s2_trim     <= s1_trim;
      s2_tg_roll  <= $signed({1'b0, s1_tune}) * $signed(cfg.damp[15:0]);
      s2_tg_pitch <= $signed({1'b0, s1_tune}) * $signed(cfg.damp[31:16]);
      s2_tg_yaw   <= $signed({1'b0, s1_tune}) * $signed(cfg.damp[47:32]);
    end
  end

  // stage 3: (tune * gain) * rate
  in_t                s3_item;
  logic signed [21:0] s3_trim;
  logic signed [46:0] s3_dp_roll;
  logic signed [46:0] s3_dp_pitch;
  logic signed [46:0] s3_dp_yaw;

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s3_item     <= s2_item;
      s3_trim     <= s2_trim;
      s3_dp_roll  <= s2_tg_roll * s2_item.roll_rate;
      s3_dp_pitch <= s2_tg_pitch * s2_item.pitch_rate;
      s3_dp_yaw   <= s2_tg_yaw * s2_item.yaw_rate;
    end
  end

  // stage 4: round damping terms (22 fraction bits off) and apply
  logic signed [47:0] r_roll;
  logic signed [47:0] r_pitch;
  logic signed [47:0] r_yaw;
  logic signed [25:0] d_roll;
  logic signed [25:0] d_pitch;
  logic signed [25:0] d_yaw;
  damp_t              mid_next;

  always_comb begin
    r_roll  = {s3_dp_roll[46], s3_dp_roll} + 48'sh20_0000;
    r_pitch = {s3_dp_pitch[46], s3_dp_pitch} + 48'sh20_0000;
    r_yaw   = {s3_dp_yaw[46], s3_dp_yaw} + 48'sh20_0000;
    d_roll  = cfg.mode[FLAG_ROLL_DAMP]  ? $signed(r_roll[47:22])  : '0;
    d_pitch = cfg.mode[FLAG_PITCH_DAMP] ? $signed(r_pitch[47:22]) : '0;
    d_yaw   = cfg.mode[FLAG_YAW_DAMP]   ? $signed(r_yaw[47:22])   : '0;
    mid_next.arm_pos = s3_item.throttle_arm > 16'sd0;
    mid_next.thr     = s3_item.throttle_command;
    mid_next.ail     = WIDE_W'(s3_item.aileron_command) - WIDE_W'(d_roll);
    mid_next.ele     = WIDE_W'(s3_item.elevator_command) + WIDE_W'(d_pitch)
                       + WIDE_W'(s3_trim);
    mid_next.rud     = WIDE_W'(s3_item.rudder_command) + WIDE_W'(d_yaw);
    mid_next.flp     = s3_item.flap_command;
    mid_next.gear    = s3_item.gear_command;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      mid <= mid_next;
    end
  end

endmodule

@@ src/smx_mix.sv @@
module smx_mix (
  input  logic               clk,
  input  smx_pkg::pipe_ctl_t ctl,
  input  smx_pkg::cfg_t      cfg,
  input  smx_pkg::damp_t     mid,
  output smx_pkg::out_t      out_data
);
  import smx_pkg::*;

  localparam logic signed [MIX_W-1:0] SAT_HI = MIX_W'(32767);
  localparam logic signed [MIX_W-1:0] SAT_LO = -MIX_W'(32768);
  localparam logic signed [MIX_W-1:0] RND12  = MIX_W'(2048);

  function automatic logic signed [15:0] sat16(input logic signed [MIX_W-1:0] v);
    logic signed [15:0] r;
    if (v > SAT_HI) begin
      r = 16'sh7fff;
    end else if (v < SAT_LO) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] rnd_sat(input logic signed [MIX_W-1:0] s);
    logic signed [MIX_W-1:0] r;
    r = (s + RND12) >>> 12;
    return sat16(r);
  endfunction

  // stage 5: autocoordination product
  damp_t              s5;
  logic signed [42:0] s5_ac;

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      s5    <= mid;
      s5_ac <= $signed(cfg.cmd_mix[15:0]) * mid.ail;
    end
  end

  // stage 6: autocoordination into rudder
  logic signed [43:0]      ac_r;
  logic signed [31:0]      ac_g;
  logic signed [RUD_W-1:0] rud_next;

  always_comb begin
    ac_r     = {s5_ac[42], s5_ac} + 44'sh800;
    ac_g     = cfg.mode[FLAG_AUTOCOORD] ? $signed(ac_r[43:12]) : '0;
    rud_next = RUD_W'(s5.rud) + RUD_W'(ac_g);
  end

  damp_t                   s6;
  logic signed [RUD_W-1:0] s6_rud;

  always_ff @(posedge clk) begin
    if (ctl.load[6]) begin
      s6     <= s5;
      s6_rud <= rud_next;
    end
  end

  // stage 7: surface mix products
  damp_t                   s7;
  logic signed [RUD_W-1:0] s7_rud;
  logic signed [MIX_W-1:0] s7_ev_a;
  logic signed [MIX_W-1:0] s7_ev_e;
  logic signed [MIX_W-1:0] s7_fp_a;
  logic signed [MIX_W-1:0] s7_fp_f;
  logic signed [MIX_W-1:0] s7_vt_e;
  logic signed [MIX_W-1:0] s7_vt_r;

  always_ff @(posedge clk) begin
    if (ctl.load[7]) begin
      s7      <= s6;
      s7_rud  <= s6_rud;
      s7_ev_a <= $signed(cfg.wing_mix[15:0]) * s6.ail;
      s7_ev_e <= $signed(cfg.wing_mix[31:16]) * s6.ele;
      s7_fp_a <= $signed(cfg.wing_mix[47:32]) * s6.ail;
      s7_fp_f <= $signed(cfg.wing_mix[63:48]) * s6.flp;
      s7_vt_e <= $signed(cfg.tail_mix[15:0]) * s6.ele;
      s7_vt_r <= $signed(cfg.tail_mix[31:16]) * s6_rud;
    end
  end

  // stage 8: sum, round, saturate, select
  out_t o;

  always_comb begin
    o.throttle_out      = s7.arm_pos ? s7.thr : '0;
    o.left_surface_out  = sat16(MIX_W'(s7.ail));
    o.pitch_surface_out = sat16(MIX_W'(s7.ele));
    o.yaw_surface_out   = sat16(MIX_W'(s7_rud));
    o.flap_out          = s7.flp;
    o.gear_out          = s7.gear;
    // elevon takes priority over flaperon and locks out vtail
    if (cfg.mode[FLAG_ELEVON]) begin
      o.left_surface_out  = rnd_sat(s7_ev_a + s7_ev_e);
      o.pitch_surface_out = rnd_sat(s7_ev_a - s7_ev_e);
    end else if (cfg.mode[FLAG_FLAPERON]) begin
      o.left_surface_out  = rnd_sat(s7_fp_a + s7_fp_f);
      o.flap_out          = rnd_sat(s7_fp_f - s7_fp_a);
    end
    if (cfg.mode[FLAG_VTAIL] && !cfg.mode[FLAG_ELEVON]) begin
      o.pitch_surface_out = rnd_sat(s7_vt_e + s7_vt_r);
      o.yaw_surface_out   = rnd_sat(s7_vt_e - s7_vt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[8]) begin
      out_data <= o;
    end
  end

endmodule
